// ===== rtl/ctau_pkg.sv =====
// Package for the circle track association unit.
// Holds shared types, register defaults, status codes and the radius scaling function.
// No dependencies.
`default_nettype none

package ctau_pkg;

    // Table size default
    localparam int MAX_TRACKS_DEF = 16;

    // Field widths
    localparam int COORD_W  = 9;
    localparam int RAD_IN_W = 8;
    localparam int RAD_W    = 9;
    localparam int FRAME_W  = 32;
    localparam int HITS_W   = 8;
    localparam int ID_W     = 16;
    localparam int CNT_W    = 5;
    localparam int SQ_W     = 2 * COORD_W;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int DIST_W     = 18;
    localparam int AGE_W      = 16;
    localparam int VIS_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DIST_SQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_HITS   = 2'd2;

    localparam logic [DIST_W-1:0] MATCH_DIST_SQ_RST  = 18'd1000;
    localparam logic [AGE_W-1:0]  MAX_AGE_FRAMES_RST = 16'd50;
    localparam logic [VIS_W-1:0]  VISIBLE_HITS_RST   = 8'd3;

    // floor(r * 105 / 100) as (r * 105 * 5243) >> 19, exact for r below 256
    localparam int SCALE_SH  = 19;
    localparam int SCALE_MUL = 105 * 5243;
    localparam int SCALE_P_W = 29;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    // Function code of an input item
    typedef enum logic {
        FN_DETECT = 1'b0,
        FN_SWEEP  = 1'b1
    } t_func;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MATCH = 3'd0,
        ST_NEW   = 3'd1,
        ST_ZERO  = 3'd2,
        ST_FULL  = 3'd3,
        ST_SWEEP = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_WALK,
        SQ_DRAIN,
        SQ_FINISH,
        SQ_DONE
    } t_seq_state;

    // One track record as held in the slot memory
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RAD_W-1:0]   radius;
        logic [FRAME_W-1:0] last_frame;
        logic [HITS_W-1:0]  hits;
        logic [ID_W-1:0]    id;
    } t_slot;

    // Configuration register set
    typedef struct packed {
        logic [DIST_W-1:0] match_dist_sq;
        logic [AGE_W-1:0]  max_age_frames;
        logic [VIS_W-1:0]  visible_hits;
    } t_cfg;

    // One result transaction
    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   new_track_id;
        logic [CNT_W-1:0]  match_count;
        logic [CNT_W-1:0]  removed_count;
        logic [CNT_W-1:0]  visible_count;
    } t_result;

    // Scale a detected radius by 1.05, rounded down
    function automatic logic [RAD_W-1:0] scale_radius(input logic [RAD_IN_W-1:0] r);
        logic [SCALE_P_W-1:0] p;
        p = SCALE_P_W'(r) * SCALE_P_W'(SCALE_MUL);
        return p[SCALE_SH +: RAD_W];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ctau_slot_mem.sv =====
// Slot memory of the circle track association unit: one write port, one read port,
// read data registered. Depends on ctau_pkg for the track record type.
`default_nettype none

module ctau_slot_mem #(
    parameter int DEPTH = ctau_pkg::MAX_TRACKS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_wr_en,
    input  wire logic [AW-1:0]  i_wr_addr,
    input  wire ctau_pkg::t_slot i_wr_data,
    input  wire logic [AW-1:0]  i_rd_addr,
    output ctau_pkg::t_slot     o_rd_data
);

    ctau_pkg::t_slot r_mem [DEPTH];
    ctau_pkg::t_slot r_rd_data;

    // Write one record
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one record; the read data is registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/ctau_seq.sv =====
// Sequencer of the circle track association unit: walks the slot memory through a
// read, evaluate and write-back pipeline, inserts tracks and builds each result.
// Depends on ctau_pkg.
`default_nettype none

module ctau_seq #(
    parameter int MAX_TRACKS = ctau_pkg::MAX_TRACKS_DEF,
    parameter int AW         = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_func,
    input  wire logic [ctau_pkg::COORD_W-1:0]      i_det_x,
    input  wire logic [ctau_pkg::COORD_W-1:0]      i_det_y,
    input  wire logic [ctau_pkg::RAD_IN_W-1:0]     i_det_radius,
    input  wire ctau_pkg::t_cfg                    i_cfg,
    input  wire logic                              i_res_take,
    output logic                                   o_busy,
    output logic                                   o_res_valid,
    output ctau_pkg::t_result                      o_res,
    output logic [AW-1:0]                          o_rd_addr,
    input  wire ctau_pkg::t_slot                   i_rd_data,
    output logic                                   o_wr_en,
    output logic [AW-1:0]                          o_wr_addr,
    output ctau_pkg::t_slot                        o_wr_data
);

    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_TRACKS - 1);

    ctau_pkg::t_seq_state r_state, n_state;

    // Per-slot flags in flip-flops
    logic [MAX_TRACKS-1:0] r_slot_valid;
    logic [MAX_TRACKS-1:0] r_slot_visible;

    // Global counters
    logic [ctau_pkg::FRAME_W-1:0] r_frame_count;
    logic [ctau_pkg::ID_W-1:0]    r_id_counter;

    // Current item
    ctau_pkg::t_func                r_func;
    logic [ctau_pkg::COORD_W-1:0]   r_det_x;
    logic [ctau_pkg::COORD_W-1:0]   r_det_y;
    logic [ctau_pkg::RAD_IN_W-1:0]  r_det_radius;
    logic [ctau_pkg::RAD_W-1:0]     r_scaled;

    // Walk and free slot search
    logic [AW-1:0] r_rd_idx;
    logic          r_free_found;
    logic [AW-1:0] r_free_idx;

    // Pipeline stage after the read is issued
    logic          r_s1_live;
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_idx;

    // Pipeline stage after evaluation
    logic                        r_s2_live;
    logic                        r_s2_valid;
    logic [AW-1:0]               r_s2_idx;
    ctau_pkg::t_slot             r_s2_slot;
    logic [ctau_pkg::SQ_W-1:0]   r_s2_sqx;
    logic [ctau_pkg::SQ_W-1:0]   r_s2_sqy;
    logic                        r_s2_age_gt;

    // Counts
    logic [ctau_pkg::CNT_W-1:0] r_match_cnt;
    logic [ctau_pkg::CNT_W-1:0] r_removed_cnt;
    logic [ctau_pkg::CNT_W-1:0] r_visible_cnt;

    ctau_pkg::t_result r_res;

    logic                          issue;
    logic                          accept;
    logic [ctau_pkg::COORD_W-1:0]  dx;
    logic [ctau_pkg::COORD_W-1:0]  dy;
    logic [ctau_pkg::FRAME_W-1:0]  age;
    logic [ctau_pkg::SQ_W:0]       dist_sum;
    logic                          c_match;
    logic                          c_stale;
    logic                          c_vis;
    logic                          do_insert;
    ctau_pkg::t_result             fin_res;
    ctau_pkg::t_slot               match_rec;
    ctau_pkg::t_slot               insert_rec;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctau_pkg::SQ_IDLE: begin
                if (i_in_valid) begin
                    n_state = ctau_pkg::SQ_WALK;
                end
            end
            ctau_pkg::SQ_WALK: begin
                if (r_rd_idx == LAST_IDX) begin
                    n_state = ctau_pkg::SQ_DRAIN;
                end
            end
            ctau_pkg::SQ_DRAIN: begin
                if (!r_s1_live && !r_s2_live) begin
                    n_state = ctau_pkg::SQ_FINISH;
                end
            end
            ctau_pkg::SQ_FINISH: begin
                n_state = ctau_pkg::SQ_DONE;
            end
            ctau_pkg::SQ_DONE: begin
                if (i_res_take) begin
                    n_state = ctau_pkg::SQ_IDLE;
                end
            end
            default: begin
                n_state = ctau_pkg::SQ_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_busy      = (r_state != ctau_pkg::SQ_IDLE);
        o_res_valid = (r_state == ctau_pkg::SQ_DONE);
        issue       = (r_state == ctau_pkg::SQ_WALK);
        accept      = (r_state == ctau_pkg::SQ_IDLE) && i_in_valid;
    end

    assign o_rd_addr = r_rd_idx;
    assign o_res     = r_res;

    // Evaluate the record coming out of memory
    always_comb begin
        dx  = (r_det_x > i_rd_data.x) ? (r_det_x - i_rd_data.x) : (i_rd_data.x - r_det_x);
        dy  = (r_det_y > i_rd_data.y) ? (r_det_y - i_rd_data.y) : (i_rd_data.y - r_det_y);
        age = r_frame_count - i_rd_data.last_frame;
    end

    // Decide match, removal and visibility for the slot in the last stage
    always_comb begin
        dist_sum = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
        c_match  = (r_func == ctau_pkg::FN_DETECT) && r_s2_valid
                   && (dist_sum < {1'b0, i_cfg.match_dist_sq});
        c_stale  = (r_func == ctau_pkg::FN_SWEEP) && r_s2_valid && r_s2_age_gt;
        c_vis    = (r_func == ctau_pkg::FN_SWEEP) && r_s2_valid && !r_s2_age_gt
                   && (r_s2_slot.hits > i_cfg.visible_hits);
    end

    // Build the updated and the inserted records
    always_comb begin
        match_rec            = r_s2_slot;
        match_rec.x          = r_det_x;
        match_rec.y          = r_det_y;
        match_rec.radius     = {1'b0, r_det_radius};
        match_rec.last_frame = r_frame_count;
        match_rec.hits       = (r_s2_slot.hits == ctau_pkg::HITS_MAX) ? r_s2_slot.hits
                                                                      : r_s2_slot.hits + 1'b1;

        insert_rec.x          = r_det_x;
        insert_rec.y          = r_det_y;
        insert_rec.radius     = r_scaled;
        insert_rec.last_frame = r_frame_count;
        insert_rec.hits       = '0;
        insert_rec.id         = r_id_counter;
    end

    // Close the item: pick the status and decide on an insert
    always_comb begin
        do_insert             = 1'b0;
        fin_res.new_track_id  = '0;
        fin_res.match_count   = '0;
        fin_res.removed_count = '0;
        fin_res.visible_count = '0;
        priority if (r_func == ctau_pkg::FN_SWEEP) begin
            fin_res.status        = ctau_pkg::ST_SWEEP;
            fin_res.removed_count = r_removed_cnt;
            fin_res.visible_count = r_visible_cnt;
        end else if (r_match_cnt != '0) begin
            fin_res.status      = ctau_pkg::ST_MATCH;
            fin_res.match_count = r_match_cnt;
        end else if (r_scaled == '0) begin
            fin_res.status = ctau_pkg::ST_ZERO;
        end else if (!r_free_found) begin
            fin_res.status = ctau_pkg::ST_FULL;
        end else begin
            fin_res.status       = ctau_pkg::ST_NEW;
            fin_res.new_track_id = r_id_counter;
            do_insert            = (r_state == ctau_pkg::SQ_FINISH);
        end
    end

    // Memory write port: update on match, otherwise insert
    always_comb begin
        o_wr_en   = c_match || do_insert;
        o_wr_addr = c_match ? r_s2_idx : r_free_idx;
        o_wr_data = c_match ? match_rec : insert_rec;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ctau_pkg::SQ_IDLE;
            r_slot_valid   <= '0;
            r_slot_visible <= '0;
            r_frame_count  <= '0;
            r_id_counter   <= '0;
            r_rd_idx       <= '0;
            r_free_found   <= 1'b0;
            r_s1_live      <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_s2_live      <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_match_cnt    <= '0;
            r_removed_cnt  <= '0;
            r_visible_cnt  <= '0;
        end else begin
            r_state <= n_state;

            // Advance the pipeline
            r_s1_live  <= issue;
            r_s1_valid <= issue && r_slot_valid[r_rd_idx];
            r_s2_live  <= r_s1_live;
            r_s2_valid <= r_s1_valid;

            // Start a new item
            if (accept) begin
                r_rd_idx      <= '0;
                r_free_found  <= 1'b0;
                r_match_cnt   <= '0;
                r_removed_cnt <= '0;
                r_visible_cnt <= '0;
            end

            // Walk the slots and note the lowest free one
            if (issue) begin
                if (r_rd_idx != LAST_IDX) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (!r_slot_valid[r_rd_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end

            // Count matches
            if (c_match) begin
                r_match_cnt <= r_match_cnt + 1'b1;
            end

            // Age out or refresh visibility
            if (c_stale) begin
                r_slot_valid[r_s2_idx]   <= 1'b0;
                r_slot_visible[r_s2_idx] <= 1'b0;
                r_removed_cnt            <= r_removed_cnt + 1'b1;
            end else if (r_func == ctau_pkg::FN_SWEEP && r_s2_valid) begin
                r_slot_visible[r_s2_idx] <= c_vis;
                if (c_vis) begin
                    r_visible_cnt <= r_visible_cnt + 1'b1;
                end
            end

            // Close the item
            if (r_state == ctau_pkg::SQ_FINISH) begin
                if (r_func == ctau_pkg::FN_SWEEP) begin
                    r_frame_count <= r_frame_count + 1'b1;
                end
                if (do_insert) begin
                    r_slot_valid[r_free_idx]   <= 1'b1;
                    r_slot_visible[r_free_idx] <= 1'b0;
                    r_id_counter               <= r_id_counter + 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func       <= ctau_pkg::t_func'(i_func);
            r_det_x      <= i_det_x;
            r_det_y      <= i_det_y;
            r_det_radius <= i_det_radius;
        end
        if (issue && !r_slot_valid[r_rd_idx] && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        r_scaled    <= ctau_pkg::scale_radius(r_det_radius);
        r_s1_idx    <= r_rd_idx;
        r_s2_idx    <= r_s1_idx;
        r_s2_slot   <= i_rd_data;
        r_s2_sqx    <= ctau_pkg::SQ_W'(dx) * ctau_pkg::SQ_W'(dx);
        r_s2_sqy    <= ctau_pkg::SQ_W'(dy) * ctau_pkg::SQ_W'(dy);
        r_s2_age_gt <= (age > ctau_pkg::FRAME_W'(i_cfg.max_age_frames));
        if (r_state == ctau_pkg::SQ_FINISH) begin
            r_res <= fin_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/circle_track_association_unit.sv =====
// Circle track association unit, top level: configuration registers, result register
// and the slot walk. Depends on ctau_pkg, ctau_slot_mem and ctau_seq.
//
// Each transaction on the input channel is one circle detection or one end-of-frame
// sweep, and produces exactly one result transaction. Track records live in a
// single-port-read slot memory of MAX_TRACKS entries. The sequencer reads every slot
// once through a three-stage read, evaluate and write-back pipeline and lets it
// drain. It then closes the item (insert of a new track or frame advance) and
// offers the result. A new item is taken only once the previous result has moved
// into the output register and the sequencer is idle again, so the block works on
// one item at a time. A finished result waits in the output register while the
// next item is already being worked on.
// Valid and visible flags reset to zero, so no clearing pass is needed.
// Configuration writes are always taken and must be made while the block is idle.
`default_nettype none

module circle_track_association_unit #(
    parameter int MAX_TRACKS = ctau_pkg::MAX_TRACKS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_func,
    input  wire logic [ctau_pkg::COORD_W-1:0]         i_det_x,
    input  wire logic [ctau_pkg::COORD_W-1:0]         i_det_y,
    input  wire logic [ctau_pkg::RAD_IN_W-1:0]        i_det_radius,
    // output channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [2:0]                                o_status,
    output logic [ctau_pkg::ID_W-1:0]                 o_new_track_id,
    output logic [ctau_pkg::CNT_W-1:0]                o_match_count,
    output logic [ctau_pkg::CNT_W-1:0]                o_removed_count,
    output logic [ctau_pkg::CNT_W-1:0]                o_visible_count,
    // configuration channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [ctau_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [ctau_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    ctau_pkg::t_cfg    r_cfg;
    logic              r_out_valid;
    ctau_pkg::t_result r_out;

    logic              busy;
    logic              res_valid;
    logic              res_take;
    ctau_pkg::t_result res;
    logic [AW-1:0]     rd_addr;
    ctau_pkg::t_slot   rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    ctau_pkg::t_slot   wr_data;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_dist_sq  <= ctau_pkg::MATCH_DIST_SQ_RST;
            r_cfg.max_age_frames <= ctau_pkg::MAX_AGE_FRAMES_RST;
            r_cfg.visible_hits   <= ctau_pkg::VISIBLE_HITS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ctau_pkg::CFG_MATCH_DIST_SQ: begin
                    r_cfg.match_dist_sq <= i_cfg_data[ctau_pkg::DIST_W-1:0];
                end
                ctau_pkg::CFG_MAX_AGE_FRAMES: begin
                    r_cfg.max_age_frames <= i_cfg_data[ctau_pkg::AGE_W-1:0];
                end
                ctau_pkg::CFG_VISIBLE_HITS: begin
                    r_cfg.visible_hits <= i_cfg_data[ctau_pkg::VIS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ctau_slot_mem #(
        .DEPTH (MAX_TRACKS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ctau_seq #(
        .MAX_TRACKS (MAX_TRACKS),
        .AW         (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_func       (i_func),
        .i_det_x      (i_det_x),
        .i_det_y      (i_det_y),
        .i_det_radius (i_det_radius),
        .i_cfg        (r_cfg),
        .i_res_take   (res_take),
        .o_busy       (busy),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    assign o_in_stall = busy;
    assign res_take   = res_valid && (!r_out_valid || !i_out_stall);

    // Hold the result until the output transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_new_track_id  = r_out.new_track_id;
    assign o_match_count   = r_out.match_count;
    assign o_removed_count = r_out.removed_count;
    assign o_visible_count = r_out.visible_count;

endmodule

`default_nettype wire

// ===== rtl/ctau_checker.sv =====
// Port checker for the circle track association unit, bound to the top level.
// Depends on ctau_pkg for the status codes.
`default_nettype none

module ctau_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [2:0]                      o_status,
    input wire logic [ctau_pkg::ID_W-1:0]       o_new_track_id,
    input wire logic [ctau_pkg::CNT_W-1:0]      o_match_count,
    input wire logic [ctau_pkg::CNT_W-1:0]      o_removed_count,
    input wire logic [ctau_pkg::CNT_W-1:0]      o_visible_count
);

    // Drop any pending result on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_new_track_id) && $stable(o_match_count)
            && $stable(o_removed_count) && $stable(o_visible_count))
        else $error("stalled result changed");

    // Work on one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // Give an id only to a new track
    a_id_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ctau_pkg::ST_NEW) |-> (o_new_track_id == '0))
        else $error("track id on a non-insert result");

    // Keep the counts consistent with the status
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ctau_pkg::ST_SWEEP) |->
            (o_removed_count == '0) && (o_visible_count == '0)
            && ((o_status == ctau_pkg::ST_MATCH) || (o_match_count == '0)))
        else $error("counts do not fit the status");

endmodule

bind circle_track_association_unit ctau_checker u_ctau_checker (.*);

`default_nettype wire

// ===== tb/circle_track_association_unit_test.sv =====
// Self-checking testbench for circle_track_association_unit: a directed table, then
// random phases under several register settings, checked against an in-bench track table.
// Depends on ctau_pkg and the RTL of circle_track_association_unit.
`default_nettype none

module circle_track_association_unit_test;

    import ctau_pkg::*;

    localparam int TRACKS      = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 6;

    // Index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // Row of the directed table: the item, and a typed expectation where one is given
    typedef struct packed {
        t_func              fn;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RAD_IN_W-1:0] r;
        bit                 typed;
        t_result            want;
    } t_stim_row;

    localparam t_result UNTYPED = '0;

    // Clock, reset and DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_func = 1'b0;
    logic [COORD_W-1:0]     i_det_x = '0;
    logic [COORD_W-1:0]     i_det_y = '0;
    logic [RAD_IN_W-1:0]    i_det_radius = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [2:0]             o_status;
    logic [ID_W-1:0]        o_new_track_id;
    logic [CNT_W-1:0]       o_match_count;
    logic [CNT_W-1:0]       o_removed_count;
    logic [CNT_W-1:0]       o_visible_count;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Shadow track table and registers, starting from their reset values
    logic [TRACKS-1:0]      trk_valid = '0;
    logic [TRACKS-1:0]      trk_visible = '0;
    logic [COORD_W-1:0]     trk_x [TRACKS];
    logic [COORD_W-1:0]     trk_y [TRACKS];
    logic [RAD_W-1:0]       trk_radius [TRACKS];
    logic [FRAME_W-1:0]     trk_last_frame [TRACKS];
    logic [HITS_W-1:0]      trk_hits [TRACKS];
    logic [ID_W-1:0]        trk_id [TRACKS];
    logic [FRAME_W-1:0]     frame_now = '0;
    logic [ID_W-1:0]        next_id = '0;
    logic [DIST_W-1:0]      gate_dist_sq = MATCH_DIST_SQ_RST;
    logic [AGE_W-1:0]       age_limit = MAX_AGE_FRAMES_RST;
    logic [VIS_W-1:0]       hits_needed = VISIBLE_HITS_RST;

    t_result                awaited_results [$];
    t_result                head_result;
    int unsigned            mismatch_total = 0;
    int unsigned            quiet_cycles = 0;
    bit                     calm = 1'b0;

    // Directed table: extremes, zero radius, table fill, full table, sweeps
    t_stim_row dir_rows [0:24] = '{
        '{FN_SWEEP,  9'd0,   9'd0,   8'd0,   1'b1, '{ST_SWEEP, 16'd0, 5'd0, 5'd0, 5'd0}},
        '{FN_DETECT, 9'd0,   9'd0,   8'd0,   1'b1, '{ST_ZERO,  16'd0, 5'd0, 5'd0, 5'd0}},
        '{FN_DETECT, 9'd0,   9'd0,   8'd1,   1'b1, '{ST_NEW,   16'd0, 5'd0, 5'd0, 5'd0}},
        '{FN_DETECT, 9'd511, 9'd511, 8'd255, 1'b1, '{ST_NEW,   16'd1, 5'd0, 5'd0, 5'd0}},
        '{FN_DETECT, 9'd511, 9'd511, 8'd0,   1'b1, '{ST_MATCH, 16'd0, 5'd1, 5'd0, 5'd0}},
        '{FN_DETECT, 9'd10,  9'd10,  8'd100, 1'b0, UNTYPED},
        '{FN_DETECT, 9'd0,   9'd511, 8'd255, 1'b0, UNTYPED},
        '{FN_DETECT, 9'd511, 9'd0,   8'd255, 1'b0, UNTYPED},
        '{FN_DETECT, 9'd100, 9'd100, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd200, 9'd100, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd300, 9'd100, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd400, 9'd100, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd100, 9'd200, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd200, 9'd200, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd300, 9'd200, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd400, 9'd200, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd100, 9'd300, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd200, 9'd300, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd300, 9'd300, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd400, 9'd300, 8'd50,  1'b0, UNTYPED},
        '{FN_DETECT, 9'd256, 9'd400, 8'd9,   1'b1, '{ST_FULL,  16'd0, 5'd0, 5'd0, 5'd0}},
        '{FN_DETECT, 9'd256, 9'd450, 8'd0,   1'b1, '{ST_ZERO,  16'd0, 5'd0, 5'd0, 5'd0}},
        '{FN_SWEEP,  9'd511, 9'd511, 8'd255, 1'b0, UNTYPED},
        '{FN_DETECT, 9'd511, 9'd511, 8'd128, 1'b0, UNTYPED},
        '{FN_SWEEP,  9'd0,   9'd0,   8'd0,   1'b0, UNTYPED}
    };

    // Register settings per random phase; raw data, wider than some registers
    logic [CFG_DATA_W-1:0] ph_dist [NUM_PHASES] = '{18'd1000, 18'd0, 18'h3FFFF,
                                                   18'd400, 18'd5000, 18'd1};
    logic [CFG_DATA_W-1:0] ph_age  [NUM_PHASES] = '{18'd50, 18'd0, 18'h3FFFF,
                                                   18'd2, 18'd10, 18'd1};
    logic [CFG_DATA_W-1:0] ph_vis  [NUM_PHASES] = '{18'd3, 18'd0, 18'd254,
                                                   18'd1, 18'h3FF00, 18'd255};
    int unsigned ph_items [NUM_PHASES] = '{100, 100, 300, 100, 100, 100};
    int unsigned ph_sweep [NUM_PHASES] = '{20, 25, 3, 20, 20, 20};

    circle_track_association_unit #(
        .MAX_TRACKS(TRACKS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_det_x        (i_det_x),
        .i_det_y        (i_det_y),
        .i_det_radius   (i_det_radius),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_new_track_id (o_new_track_id),
        .o_match_count  (o_match_count),
        .o_removed_count(o_removed_count),
        .o_visible_count(o_visible_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Associate one item with the shadow table and return the result it must produce
    function automatic t_result associate_item(input t_func fn, input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [RAD_IN_W-1:0] r);
        t_result        res;
        int unsigned    dx, dy, scaled, hit_n, gone_n, shown_n;
        int             free_slot;
        logic [FRAME_W-1:0] age;
        res = '0;
        hit_n = 0;
        gone_n = 0;
        shown_n = 0;
        if (fn == FN_DETECT) begin
            // update every track inside the gate
            for (int i = 0; i < TRACKS; i++) begin
                if (trk_valid[i]) begin
                    dx = (x > trk_x[i]) ? int'(x - trk_x[i]) : int'(trk_x[i] - x);
                    dy = (y > trk_y[i]) ? int'(y - trk_y[i]) : int'(trk_y[i] - y);
                    if (dx * dx + dy * dy < int'(gate_dist_sq)) begin
                        trk_x[i] = x;
                        trk_y[i] = y;
                        trk_radius[i] = RAD_W'(r);
                        trk_last_frame[i] = frame_now;
                        if (trk_hits[i] != HITS_MAX)
                            trk_hits[i] = trk_hits[i] + 1'b1;
                        hit_n++;
                    end
                end
            end
            if (hit_n > 0) begin
                res.status = ST_MATCH;
            end else begin
                // insert in the lowest free slot unless dropped or full
                scaled = (int'(r) * 105) / 100;
                free_slot = -1;
                for (int i = TRACKS - 1; i >= 0; i--)
                    if (!trk_valid[i])
                        free_slot = i;
                if (scaled == 0) begin
                    res.status = ST_ZERO;
                end else if (free_slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    trk_valid[free_slot] = 1'b1;
                    trk_x[free_slot] = x;
                    trk_y[free_slot] = y;
                    trk_radius[free_slot] = RAD_W'(scaled);
                    trk_last_frame[free_slot] = frame_now;
                    trk_hits[free_slot] = '0;
                    trk_visible[free_slot] = 1'b0;
                    trk_id[free_slot] = next_id;
                    res.new_track_id = next_id;
                    next_id = next_id + 1'b1;
                    res.status = ST_NEW;
                end
            end
        end else begin
            // age out stale tracks, refresh visibility of the rest
            for (int i = 0; i < TRACKS; i++) begin
                if (trk_valid[i]) begin
                    age = frame_now - trk_last_frame[i];
                    if (age > FRAME_W'(age_limit)) begin
                        trk_valid[i] = 1'b0;
                        trk_visible[i] = 1'b0;
                        gone_n++;
                    end else begin
                        trk_visible[i] = trk_hits[i] > hits_needed;
                        if (trk_visible[i])
                            shown_n++;
                    end
                end
            end
            frame_now = frame_now + 1'b1;
            res.status = ST_SWEEP;
        end
        res.match_count = CNT_W'(hit_n);
        res.removed_count = CNT_W'(gone_n);
        res.visible_count = CNT_W'(shown_n);
        return res;
    endfunction

    // Offer one detection or sweep, after a random gap unless calm is set; predict it once accepted
    task automatic send_item(input t_func fn, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [RAD_IN_W-1:0] r,
                             input bit typed, input t_result want);
        t_result predicted;
        while (!calm && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= fn;
        i_det_x      <= x;
        i_det_y      <= y;
        i_det_radius <= r;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = associate_item(fn, x, y, r);
        if (typed)
            predicted = want;
        awaited_results = {awaited_results, predicted};
    endtask

    // Write one register; the caller drops valid after the last write of a group
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_MATCH_DIST_SQ:  gate_dist_sq = DIST_W'(data);
            CFG_MAX_AGE_FRAMES: age_limit = AGE_W'(data);
            CFG_VISIBLE_HITS:   hits_needed = VIS_W'(data);
            default: ;
        endcase
    endtask

    // Hold off until every result is back and the block has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (TRACKS + 8) @(posedge i_clk);
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                if (mismatch_total < 10)
                    $display("unexpected result: status %0d id %0d match %0d removed %0d vis %0d",
                             o_status, o_new_track_id, o_match_count, o_removed_count,
                             o_visible_count);
                mismatch_total++;
            end else begin
                head_result = awaited_results.pop_front();
                if (o_status !== 3'(head_result.status) ||
                    o_new_track_id !== head_result.new_track_id ||
                    o_match_count !== head_result.match_count ||
                    o_removed_count !== head_result.removed_count ||
                    o_visible_count !== head_result.visible_count) begin
                    if (mismatch_total < 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 head_result.status, head_result.new_track_id,
                                 head_result.match_count, head_result.removed_count,
                                 head_result.visible_count, o_status, o_new_track_id,
                                 o_match_count, o_removed_count, o_visible_count);
                    mismatch_total++;
                end
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 37);
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_func              fn;
        logic [COORD_W-1:0] rx, ry;
        logic [RAD_IN_W-1:0] rr;
        int unsigned        slot, spread;
        int                 px, py;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[k])
            send_item(dir_rows[k].fn, dir_rows[k].x, dir_rows[k].y, dir_rows[k].r,
                      dir_rows[k].typed, dir_rows[k].want);
        settle();

        // random phases, one register setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            calm = (ph == 3);
            if (ph == 4)
                write_reg(CFG_UNUSED_IDX, 18'h2AAAA);
            write_reg(CFG_MATCH_DIST_SQ, ph_dist[ph]);
            write_reg(CFG_MAX_AGE_FRAMES, ph_age[ph]);
            write_reg(CFG_VISIBLE_HITS, ph_vis[ph]);
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < int'(ph_items[ph]); n++) begin
                rx = COORD_W'($urandom_range(511));
                ry = COORD_W'($urandom_range(511));
                rr = RAD_IN_W'($urandom_range(255));
                if ($urandom_range(99) < ph_sweep[ph]) begin
                    fn = FN_SWEEP;
                end else begin
                    fn = FN_DETECT;
                    // mostly land near a live track so matches and updates happen
                    if (trk_valid != '0 && $urandom_range(99) < 65) begin
                        slot = $urandom_range(TRACKS - 1);
                        while (!trk_valid[slot])
                            slot = $urandom_range(TRACKS - 1);
                        spread = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1);
                        px = int'(trk_x[slot]) + int'($urandom_range(2 * spread)) - int'(spread);
                        py = int'(trk_y[slot]) + int'($urandom_range(2 * spread)) - int'(spread);
                        rx = COORD_W'((px < 0) ? 0 : (px > 511) ? 511 : px);
                        ry = COORD_W'((py < 0) ? 0 : (py > 511) ? 511 : py);
                    end
                    if ($urandom_range(19) == 0)
                        rr = '0;
                end
                send_item(fn, rx, ry, rr, 1'b0, UNTYPED);
            end
            settle();
        end

        if (mismatch_total == 0 && awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
